// ===== rtl/fmec_pkg.sv =====
// fmec_pkg: shared types and helpers for the float mantissa/exponent coder
// no dependencies; used by every stage module and the top level
`timescale 1ns / 1ps
`default_nettype none

package fmec_pkg;

  localparam int unsigned FloatW   = 32;
  localparam int unsigned MantW    = 14;
  localparam int unsigned ExpW     = 8;
  localparam int unsigned CodeW    = 30;
  localparam int unsigned LenW     = 5;
  localparam int unsigned HeadW    = 8;
  localparam int unsigned TailW    = 22;
  localparam logic [ExpW-1:0] ExpBias   = 8'd127;
  localparam logic [LenW-1:0] ZeroLen   = 5'd4;
  localparam logic [LenW-1:0] HeadLen   = 5'd8;

  // decoded fields after the first stage
  typedef struct packed {
    logic            zero;
    logic            sign;
    logic [MantW-1:0] mant;
    logic [3:0]      mbits;
    logic            e_nz;
    logic            esign;
    logic [ExpW-1:0] emag;   // magnitude with leading one removed
    logic [3:0]      elen;   // bit length of magnitude, 0..8
  } s1_t;

  // header and mantissa/exponent tail after the second stage
  typedef struct packed {
    logic             zero;
    logic [HeadW-1:0] head;
    logic [TailW-1:0] mt;
    logic [LenW-1:0]  mt_len;
  } s2_t;

  // position of the highest set bit plus one, 0 when empty
  function automatic logic [3:0] bit_len14(input logic [MantW-1:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < MantW; i++) begin
      if (v[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [3:0] bit_len8(input logic [ExpW-1:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < ExpW; i++) begin
      if (v[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fmec_decode.sv =====
// fmec_decode: first stage, splits the float word and finds field lengths
// depends on fmec_pkg
`timescale 1ns / 1ps
`default_nettype none

module fmec_decode (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [fmec_pkg::FloatW-1:0] float_word,
  output fmec_pkg::s1_t                    q
);

  fmec_pkg::s1_t               q_next;
  logic [fmec_pkg::ExpW-1:0]   efield;
  logic [fmec_pkg::ExpW-1:0]   emag;
  logic [3:0]                  elen;
  logic [2:0]                  top_pos;

  always_comb begin
    efield  = float_word[30:23];
    if (efield >= fmec_pkg::ExpBias) begin
      emag = efield - fmec_pkg::ExpBias;
    end else begin
      emag = fmec_pkg::ExpBias - efield;
    end
    elen    = fmec_pkg::bit_len8(emag);
    top_pos = 3'(elen - 4'd1);

    q_next.zero  = (float_word[30:0] == 31'd0);
    q_next.sign  = float_word[31];
    q_next.mant  = float_word[22:9];
    q_next.mbits = fmec_pkg::bit_len14(float_word[22:9]);
    q_next.e_nz  = (efield != fmec_pkg::ExpBias);
    q_next.esign = (efield < fmec_pkg::ExpBias);
    q_next.elen  = elen;
    if (q_next.e_nz) begin
      q_next.emag = emag ^ (8'd1 << top_pos);
    end else begin
      q_next.emag = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fmec_pack.sv =====
// fmec_pack: second stage, builds the header and joins mantissa and exponent
// depends on fmec_pkg
`timescale 1ns / 1ps
`default_nettype none

module fmec_pack (
  input  wire logic  clk,
  input  wire logic  en,
  input  wire fmec_pkg::s1_t d,
  output fmec_pkg::s2_t q
);

  fmec_pkg::s2_t              q_next;
  logic [fmec_pkg::ExpW-1:0]  tail;
  logic [3:0]                 tail_len;
  logic [2:0]                 top_pos;

  always_comb begin
    top_pos = 3'(d.elen - 4'd1);
    if (d.e_nz) begin
      tail     = ({7'd0, d.esign} << top_pos) | d.emag;
      tail_len = d.elen;
    end else begin
      tail     = '0;
      tail_len = 4'd0;
    end
    q_next.zero   = d.zero;
    // count field plus one, exponent length cut to three bits, sign
    q_next.head   = {4'(d.mbits + 4'd1), d.elen[2:0], d.sign};
    q_next.mt     = ({8'd0, d.mant} << tail_len)
                    | {{(fmec_pkg::TailW - fmec_pkg::ExpW){1'b0}}, tail};
    q_next.mt_len = 5'(d.mbits) + 5'(tail_len);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fmec_align.sv =====
// fmec_align: last stage, places the header above the tail into the output register
// depends on fmec_pkg
`timescale 1ns / 1ps
`default_nettype none

module fmec_align (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire fmec_pkg::s2_t              d,
  output logic [fmec_pkg::CodeW-1:0]      code_bits,
  output logic [fmec_pkg::LenW-1:0]       code_length
);

  logic [fmec_pkg::CodeW-1:0] code_bits_next;
  logic [fmec_pkg::LenW-1:0]  code_length_next;

  always_comb begin
    if (d.zero) begin
      code_bits_next   = '0;
      code_length_next = fmec_pkg::ZeroLen;
    end else begin
      code_bits_next   = ({22'd0, d.head} << d.mt_len) | {8'd0, d.mt};
      code_length_next = fmec_pkg::HeadLen + d.mt_len;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code_bits   <= code_bits_next;
      code_length <= code_length_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/float_mantissa_exponent_coder.sv =====
// float_mantissa_exponent_coder: top level, three-stage pipeline with valid bits
// depends on fmec_pkg, fmec_decode, fmec_pack, fmec_align
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------
//  input   | in_valid / in_ready | float_word (32)
//  output  | out_valid/out_ready | code_bits (30), code_length (5)
//
// the accepted word is registered in decode, pack and align in turn, and out_valid
// rises once it reaches align; one item per cycle sustained while out_ready is high,
// through the three register stages (decode, pack, align)
// each stage loads when it is empty or the stage after it moves, so bubbles
// close up and a stalled output holds the whole pipe without loss
// rst clears the three valid bits only; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module float_mantissa_exponent_coder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [fmec_pkg::FloatW-1:0] float_word,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [fmec_pkg::CodeW-1:0]       code_bits,
  output logic [fmec_pkg::LenW-1:0]        code_length
);

  // stage valid bits travel with the data
  logic v1, v2, v3;
  logic en1, en2, en3;

  fmec_pkg::s1_t s1;
  fmec_pkg::s2_t s2;

  // a stage may load when empty or when its contents move on
  assign en3 = !v3 || out_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign in_ready  = en1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // decode: sign, mantissa top bits, exponent magnitude and lengths
  fmec_decode u_decode (
    .clk        (clk),
    .en         (en1),
    .float_word (float_word),
    .q          (s1)
  );

  // pack: header byte and mantissa followed by exponent code
  fmec_pack u_pack (
    .clk (clk),
    .en  (en2),
    .d   (s1),
    .q   (s2)
  );

  // align: header shifted above the tail, zero value forced to four zero bits
  fmec_align u_align (
    .clk         (clk),
    .en          (en3),
    .d           (s2),
    .code_bits   (code_bits),
    .code_length (code_length)
  );

endmodule

`default_nettype wire

// ===== rtl/fmec_checker.sv =====
// fmec_checker: port-level assertions for the coder, bound to the top level
// depends on fmec_pkg and float_mantissa_exponent_coder
`timescale 1ns / 1ps
`default_nettype none

module fmec_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [fmec_pkg::CodeW-1:0]  code_bits,
  input wire logic [fmec_pkg::LenW-1:0]   code_length
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_bits) && $stable(code_length))
    else $error("result changed while stalled");

  // length within the code's range
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> code_length >= 5'd4 && code_length <= 5'd30)
    else $error("code length out of range");

  // no bits above the stated length
  a_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(code_bits) >> code_length) == 32'd0)
    else $error("bits set above code length");

  // a nonzero value always leads with a nonzero count field
  a_head: assert property (@(posedge clk) disable iff (rst)
    out_valid && code_length != 5'd4 |-> (32'(code_bits) >> (code_length - 5'd4)) != 32'd0)
    else $error("count field zero");

endmodule

bind float_mantissa_exponent_coder fmec_checker u_fmec_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .code_bits   (code_bits),
  .code_length (code_length)
);

`default_nettype wire
